// File: hdl/mtd_pkg.sv
// Shared types and constants of the Morse text decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package mtd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // One queue entry: the one or two characters caused by one input item.
  typedef struct packed {
    logic       two;
    logic [7:0] char0;
    logic [7:0] char1;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_SKIP  = 2'd0,
    MODE_TOKEN = 2'd1,
    MODE_GAP   = 2'd2
  } mode_t;

  localparam logic [2:0] MAX_SYMBOLS = 3'd5;
  localparam logic [2:0] GAP_LIMIT   = 3'd4;
  localparam logic [2:0] SPACE_MAX   = 3'd7;
  localparam int         NUM_CODES   = 36;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DASH    = 8'h2D;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
    logic [7:0] ch;
  } code_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } match_t;

  // Code length, symbols (first symbol in bit 0, dash = 1), character.
  localparam code_t CODE_TABLE [NUM_CODES] = '{
    '{3'd2, 5'd2,  8'h41}, '{3'd4, 5'd1,  8'h42}, '{3'd4, 5'd5,  8'h43},
    '{3'd3, 5'd1,  8'h44}, '{3'd1, 5'd0,  8'h45}, '{3'd4, 5'd4,  8'h46},
    '{3'd3, 5'd3,  8'h47}, '{3'd4, 5'd0,  8'h48}, '{3'd2, 5'd0,  8'h49},
    '{3'd4, 5'd14, 8'h4A}, '{3'd3, 5'd5,  8'h4B}, '{3'd4, 5'd2,  8'h4C},
    '{3'd2, 5'd3,  8'h4D}, '{3'd2, 5'd1,  8'h4E}, '{3'd3, 5'd7,  8'h4F},
    '{3'd4, 5'd6,  8'h50}, '{3'd4, 5'd11, 8'h51}, '{3'd3, 5'd2,  8'h52},
    '{3'd3, 5'd0,  8'h53}, '{3'd1, 5'd1,  8'h54}, '{3'd3, 5'd4,  8'h55},
    '{3'd4, 5'd8,  8'h56}, '{3'd3, 5'd6,  8'h57}, '{3'd4, 5'd9,  8'h58},
    '{3'd4, 5'd13, 8'h59}, '{3'd4, 5'd3,  8'h5A},
    '{3'd5, 5'd30, 8'h31}, '{3'd5, 5'd28, 8'h32}, '{3'd5, 5'd24, 8'h33},
    '{3'd5, 5'd16, 8'h34}, '{3'd5, 5'd0,  8'h35}, '{3'd5, 5'd1,  8'h36},
    '{3'd5, 5'd3,  8'h37}, '{3'd5, 5'd7,  8'h38}, '{3'd5, 5'd15, 8'h39},
    '{3'd5, 5'd31, 8'h30}
  };

  // Codes are unique, so an OR over all entries gives the single match.
  function automatic match_t lookup(input logic [2:0] len, input logic [4:0] bits);
    match_t m;
    m = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_TABLE[i].len == len && CODE_TABLE[i].bits == bits) begin
        m.hit = 1'b1;
        m.ch  = m.ch | CODE_TABLE[i].ch;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: hdl/mtd_front.sv
// Front end: takes text bytes, tracks token and space-run state, and
// queues the characters each byte causes. Depends on mtd_pkg.
`default_nettype none
module mtd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mtd_pkg::in_item_t item,
  input  wire logic              full,
  output logic                   push,
  output mtd_pkg::entry_t        push_data
);

  mtd_pkg::mode_t mode, mode_next;
  logic [4:0] code_bits, code_bits_next;
  logic [2:0] code_length, code_length_next;
  logic       token_invalid, token_invalid_next;
  logic [2:0] space_count, space_count_next;

  logic           accept, ws, is_dot, is_dash, is_sym, gap_long, tok_hit;
  logic [7:0]     b;
  mtd_pkg::match_t tok;
  logic           a_v, b_v;
  logic [7:0]     a_c;

  assign item_ready = !full;
  assign accept     = item_valid && !full;
  assign b          = item.in_byte;
  assign ws         = (b == mtd_pkg::CH_SPACE) ||
                      (b >= mtd_pkg::CH_TAB && b <= mtd_pkg::CH_CR);
  assign is_dot     = (b == mtd_pkg::CH_DOT);
  assign is_dash    = (b == mtd_pkg::CH_DASH);
  assign is_sym     = is_dot || is_dash;
  assign gap_long   = space_count > mtd_pkg::GAP_LIMIT;
  assign tok        = mtd_pkg::lookup(code_length, code_bits);
  assign tok_hit    = tok.hit && !token_invalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= mtd_pkg::MODE_SKIP;
      code_bits     <= '0;
      code_length   <= '0;
      token_invalid <= 1'b0;
      space_count   <= '0;
    end else if (accept) begin
      mode          <= mode_next;
      code_bits     <= code_bits_next;
      code_length   <= code_length_next;
      token_invalid <= token_invalid_next;
      space_count   <= space_count_next;
    end
  end

  always_comb begin
    mode_next          = mode;
    code_bits_next     = code_bits;
    code_length_next   = code_length;
    token_invalid_next = token_invalid;
    space_count_next   = space_count;
    a_v = 1'b0;
    a_c = mtd_pkg::CH_SPACE;
    b_v = 1'b0;
    if (item.end_of_input) begin
      // flush, then back to reset state
      if (mode == mtd_pkg::MODE_TOKEN) begin
        a_v = tok_hit;
        a_c = tok.ch;
      end else if (mode == mtd_pkg::MODE_GAP) begin
        a_v = gap_long;
      end
      mode_next          = mtd_pkg::MODE_SKIP;
      code_bits_next     = '0;
      code_length_next   = '0;
      token_invalid_next = 1'b0;
      space_count_next   = '0;
    end else begin
      unique case (mode)
        mtd_pkg::MODE_TOKEN: begin
          if (ws) begin
            a_v = tok_hit;
            a_c = tok.ch;
            space_count_next = '0;
            if (b == mtd_pkg::CH_SPACE) begin
              space_count_next = 3'd1;
              mode_next        = mtd_pkg::MODE_GAP;
            end else begin
              b_v       = (b == mtd_pkg::CH_NEWLINE);
              mode_next = mtd_pkg::MODE_SKIP;
            end
          end else if (!is_sym || code_length >= mtd_pkg::MAX_SYMBOLS) begin
            token_invalid_next = 1'b1;
          end else begin
            code_bits_next   = code_bits | (5'(is_dash) << code_length);
            code_length_next = code_length + 3'd1;
          end
        end
        mtd_pkg::MODE_GAP: begin
          if (b == mtd_pkg::CH_SPACE) begin
            if (space_count != mtd_pkg::SPACE_MAX) begin
              space_count_next = space_count + 3'd1;
            end
          end else begin
            if (gap_long) begin
              a_v = 1'b1;
            end else if (b == mtd_pkg::CH_NEWLINE) begin
              a_v = 1'b1;
              a_c = mtd_pkg::CH_NEWLINE;
            end
            space_count_next = '0;
            if (ws) begin
              mode_next = mtd_pkg::MODE_SKIP;
            end else begin
              mode_next          = mtd_pkg::MODE_TOKEN;
              code_bits_next     = {4'd0, is_dash};
              code_length_next   = {2'd0, is_sym};
              token_invalid_next = !is_sym;
            end
          end
        end
        default: begin
          // skipping whitespace; the unused mode code behaves the same
          mode_next = mtd_pkg::MODE_SKIP;
          if (!ws) begin
            mode_next          = mtd_pkg::MODE_TOKEN;
            code_bits_next     = {4'd0, is_dash};
            code_length_next   = {2'd0, is_sym};
            token_invalid_next = !is_sym;
            space_count_next   = '0;
          end
        end
      endcase
    end
  end

  always_comb begin
    push            = accept && (a_v || b_v);
    push_data.two   = a_v && b_v;
    push_data.char0 = a_v ? a_c : mtd_pkg::CH_NEWLINE;
    push_data.char1 = mtd_pkg::CH_NEWLINE;
  end

endmodule
`default_nettype wire

// File: hdl/mtd_fifo.sv
// Small queue of result entries between front and back end.
// Depends on mtd_pkg for the entry type.
`default_nettype none
module mtd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mtd_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output mtd_pkg::entry_t      pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtd_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/mtd_back.sv
// Back end: output register that sends each queued entry as one or two
// result transfers. Depends on mtd_pkg.
`default_nettype none
module mtd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            empty,
  input  wire mtd_pkg::entry_t pop_data,
  output logic                 pop,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output mtd_pkg::out_item_t   result
);

  mtd_pkg::entry_t cur;
  logic            busy;
  logic            second;
  logic            is_last;
  logic            done;

  assign is_last      = !cur.two || second;
  assign result_valid = busy;
  assign result.out_char = second ? cur.char1 : cur.char0;
  assign result.last     = is_last;
  assign done         = busy && result_ready && is_last;
  assign pop          = !empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (pop) begin
      busy   <= 1'b1;
      second <= 1'b0;
    end else if (done) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (busy && result_ready) begin
      second <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hdl/morse_text_decoder.sv
// Top level of the Morse text decoder: front end, result queue, back end.
// Depends on mtd_pkg, mtd_front, mtd_fifo and mtd_back.
`default_nettype none
// Decodes ASCII text of dot/dash tokens, one byte per input transfer, into
// letters A-Z, digits 0-9, spaces (after more than four spaces between
// tokens) and newlines. Input bytes are taken one per cycle while the result
// queue has room; the front end updates the token state and looks up a
// finished token in the same cycle it takes the byte. A byte may cause zero,
// one or two characters; they are queued as one entry and the back end sends
// them at one result transfer per cycle while result_ready is high, with last
// set on the final one. Each entry passes the queue, then the output register.
// Sustained input rate is one byte per cycle; it drops only when the output
// side stalls long enough that the QUEUE_DEPTH-entry queue fills. An input
// with end_of_input set flushes a pending token or space run and returns the
// parser to its reset state; in_byte is ignored in that transfer.
module morse_text_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire mtd_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output mtd_pkg::out_item_t      result
);

  logic            push, full, pop, empty;
  mtd_pkg::entry_t push_data, pop_data;

  // parser and token lookup
  mtd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .full       (full),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples input transfers from output stalls
  mtd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (pop_data)
  );

  // serializes each entry into result transfers
  mtd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// File: dv/morse_decode_check.sv
// Checker for the Morse text decoder: predicts decoded characters, compares results.
// Depends on mtd_pkg for the transfer payload types and character constants.
`default_nettype none
module morse_decode_check (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  input  wire logic               item_ready,
  input  wire mtd_pkg::in_item_t  item,
  input  wire logic               result_valid,
  input  wire logic               result_ready,
  input  wire mtd_pkg::out_item_t result,
  output int                      mismatches,
  output int                      pending
);

  // Predicted parser state
  mtd_pkg::mode_t mode;
  logic [4:0]     code;
  logic [2:0]     code_len;
  logic           bad_token;
  logic [2:0]     spaces;

  mtd_pkg::out_item_t expected_chars[$];
  mtd_pkg::out_item_t want;
  logic [7:0]         burst[2];
  int                 burst_n;
  int                 errs;

  function automatic string morse_of(input logic [7:0] ch);
    unique case (ch)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";  "D": return "-..";
      "E": return ".";     "F": return "..-.";  "G": return "--.";   "H": return "....";
      "I": return "..";    "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";   "P": return ".--.";
      "Q": return "--.-";  "R": return ".-.";   "S": return "...";   "T": return "-";
      "U": return "..-";   "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---"; "3": return "...--";
      "4": return "....-"; "5": return "....."; "6": return "-...."; "7": return "--...";
      "8": return "---.."; "9": return "----.";
      default: return "";
    endcase
  endfunction

  // {hit, char} for a finished token; symbols packed first-in-bit-0, dash = 1
  function automatic logic [8:0] char_for_code(input logic [2:0] len,
                                               input logic [4:0] bits);
    logic [7:0] ch;
    string      pat;
    logic [4:0] pbits;
    for (int i = 0; i < 36; i++) begin
      ch = (i < 26) ? 8'h41 + i[7:0] : 8'h30 + (i[7:0] - 8'd26);
      pat = morse_of(ch);
      pbits = '0;
      for (int k = 0; k < pat.len(); k++)
        if (pat[k] == mtd_pkg::CH_DASH) pbits[k] = 1'b1;
      if (pat.len() == len && pbits == bits) return {1'b1, ch};
    end
    return '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == mtd_pkg::CH_SPACE || (b >= mtd_pkg::CH_TAB && b <= mtd_pkg::CH_CR);
  endfunction

  task automatic emit(input logic [7:0] c);
    if (burst_n < 2) begin
      burst[burst_n] = c;
      burst_n = burst_n + 1;
    end
  endtask

  task automatic add_symbol(input logic [7:0] b);
    if (b != mtd_pkg::CH_DOT && b != mtd_pkg::CH_DASH) begin
      bad_token = 1'b1;
    end else if (code_len >= mtd_pkg::MAX_SYMBOLS) begin
      bad_token = 1'b1;
    end else begin
      if (b == mtd_pkg::CH_DASH) code[code_len] = 1'b1;
      code_len = code_len + 3'd1;
    end
  endtask

  task automatic open_token(input logic [7:0] b);
    code      = '0;
    code_len  = '0;
    bad_token = 1'b0;
    spaces    = '0;
    mode      = mtd_pkg::MODE_TOKEN;
    add_symbol(b);
  endtask

  task automatic close_token();
    logic [8:0] m;
    if (!bad_token) begin
      m = char_for_code(code_len, code);
      if (m[8]) emit(m[7:0]);
    end
    spaces = '0;
  endtask

  // Space run (or token) ended by a byte other than a space
  task automatic close_gap(input logic [7:0] b);
    if (spaces > mtd_pkg::GAP_LIMIT) emit(mtd_pkg::CH_SPACE);
    else if (b == mtd_pkg::CH_NEWLINE) emit(mtd_pkg::CH_NEWLINE);
    spaces = '0;
    if (is_blank(b)) mode = mtd_pkg::MODE_SKIP;
    else open_token(b);
  endtask

  task automatic clear_parser();
    mode      = mtd_pkg::MODE_SKIP;
    code      = '0;
    code_len  = '0;
    bad_token = 1'b0;
    spaces    = '0;
  endtask

  task automatic predict_decode(input mtd_pkg::in_item_t it);
    mtd_pkg::out_item_t o;
    logic [7:0] b;
    b = it.in_byte;
    burst_n = 0;
    if (it.end_of_input) begin
      if (mode == mtd_pkg::MODE_TOKEN) close_token();
      else if (mode == mtd_pkg::MODE_GAP && spaces > mtd_pkg::GAP_LIMIT)
        emit(mtd_pkg::CH_SPACE);
      clear_parser();
    end else begin
      unique case (mode)
        mtd_pkg::MODE_TOKEN: begin
          if (is_blank(b)) begin
            close_token();
            if (b == mtd_pkg::CH_SPACE) begin
              spaces = 3'd1;
              mode   = mtd_pkg::MODE_GAP;
            end else begin
              close_gap(b);
            end
          end else begin
            add_symbol(b);
          end
        end
        mtd_pkg::MODE_GAP: begin
          if (b == mtd_pkg::CH_SPACE) begin
            if (spaces < mtd_pkg::SPACE_MAX) spaces = spaces + 3'd1;
          end else begin
            close_gap(b);
          end
        end
        default: begin
          mode = mtd_pkg::MODE_SKIP;
          if (!is_blank(b)) open_token(b);
        end
      endcase
    end
    for (int i = 0; i < burst_n; i++) begin
      o.out_char = burst[i];
      o.last     = (i == burst_n - 1);
      expected_chars.push_back(o);
    end
  endtask

  // Results are checked before the same edge's input is predicted; an input
  // cannot cause a result at the edge it is taken.
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_chars.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: expected none, got %02h (last %0b)", result.out_char, result.last);
          errs = errs + 1;
        end else begin
          want = expected_chars.pop_front();
          if (result.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, result.out_char);
            errs = errs + 1;
          end
          if (result.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result.last);
            errs = errs + 1;
          end
        end
      end
      if (item_valid && item_ready) predict_decode(item);
    end
    pending    <= expected_chars.size();
    mismatches <= errs;
  end

endmodule
`default_nettype wire

// File: dv/morse_text_decoder_tb.sv
// Testbench top for the Morse text decoder: clock, reset, stimulus, verdict.
// Depends on mtd_pkg, morse_text_decoder and the morse_decode_check checker.
`default_nettype none
module morse_text_decoder_tb;

  // Blanks the package does not name
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;

  // Each cycle is 10 units; the limit is meant to leave several times a worst
  // case run as margin.
  localparam int RUN_LIMIT   = 5_000_000;
  localparam int NUM_ITEMS   = 1300;
  localparam int DRAIN_WAIT  = 20;   // past the result latency plus queue
  localparam int LONG_HOLD   = 300;  // receiver hold-off, fills the queue

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  mtd_pkg::in_item_t  item;
  logic               result_valid;
  logic               result_ready;
  mtd_pkg::out_item_t result;
  int                 mismatches;
  int                 pending;

  int        sent;
  logic      tx_steady;   // sender runs back to back while set
  logic      rx_steady;   // receiver takes results without stalls while set, long holds apart

  morse_text_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Watches both channels, predicts every character and compares.
  morse_decode_check decode_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: a hung handshake ends here.
  initial begin
    #RUN_LIMIT;
    $display("Test completed with failures");
    $finish;
  end

  // One input transfer. The gap before it is drawn per item; in steady
  // stretches it is zero so valid stays high across items. Ready is read
  // right after the edge, i.e. the value the edge itself saw.
  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid        <= 1'b1;
    item.in_byte      <= b;
    item.end_of_input <= eoi;
    do @(posedge clk); while (!item_ready);
    sent = sent + 1;
    if (sent % 64 == 0) tx_steady = ($urandom_range(0, 2) == 0);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Hold the input side until the checker has seen every predicted result.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] any_blank();
    unique case ($urandom_range(0, 5))
      0: return mtd_pkg::CH_SPACE;
      1: return mtd_pkg::CH_TAB;
      2: return mtd_pkg::CH_NEWLINE;
      3: return CH_VT;
      4: return CH_FF;
      default: return mtd_pkg::CH_CR;
    endcase
  endfunction

  // One random word: mostly a dot/dash token of 1..5 symbols (most
  // of those are real codes), some overlong or with a foreign byte, then a
  // separator. A few words are plain noise bytes.
  task automatic send_word();
    int kind, len, sep, n;
    logic [7:0] b;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    len = (kind == 1) ? $urandom_range(6, 7) : $urandom_range(1, 5);
    for (int i = 0; i < len; i++) begin
      b = $urandom_range(0, 1) ? mtd_pkg::CH_DASH : mtd_pkg::CH_DOT;
      if (kind == 2 && i == len - 1) begin
        // foreign symbol: any byte that is not blank
        b = 8'($urandom_range(0, 255));
        if (b == mtd_pkg::CH_SPACE || (b >= mtd_pkg::CH_TAB && b <= mtd_pkg::CH_CR))
          b = 8'h00;
      end
      send_item(b, 1'b0);
    end
    sep = $urandom_range(0, 15);
    if (sep <= 6) begin
      send_item(mtd_pkg::CH_SPACE, 1'b0);
    end else if (sep <= 8) begin
      n = $urandom_range(2, 4);
      repeat (n) send_item(mtd_pkg::CH_SPACE, 1'b0);
    end else if (sep <= 10) begin
      // long gap: gives a space, count saturates past seven
      n = $urandom_range(5, 9);
      repeat (n) send_item(mtd_pkg::CH_SPACE, 1'b0);
    end else if (sep == 11) begin
      send_item(mtd_pkg::CH_NEWLINE, 1'b0);
    end else if (sep == 12) begin
      n = $urandom_range(1, 6);
      repeat (n) send_item(mtd_pkg::CH_SPACE, 1'b0);
      send_item(mtd_pkg::CH_NEWLINE, 1'b0);
    end else if (sep == 13) begin
      n = $urandom_range(1, 3);
      repeat (n) send_item(any_blank(), 1'b0);
    end else if (sep == 14) begin
      n = $urandom_range(0, 7);
      repeat (n) send_item(mtd_pkg::CH_SPACE, 1'b0);
      send_item(any_blank(), 1'b0);
    end else begin
      // end marker, sometimes after a gap; in_byte must not matter
      n = $urandom_range(0, 6);
      repeat (n) send_item(mtd_pkg::CH_SPACE, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Receiver: draws a stall per result, with steady stretches, and twice
  // holds off for a long stretch so the queue fills and input stalls.
  initial begin : receiver
    int stall;
    int taken;
    taken        = 0;
    rx_steady    = 1'b0;
    result_ready = 1'b0;
    forever begin
      if (taken == 30 || taken == 120) stall = LONG_HOLD;
      else stall = rx_steady ? 0 : $urandom_range(0, 17);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      taken = taken + 1;
      if (taken % 40 == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic paused;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    sent       = 0;
    tx_steady  = 1'b0;
    paused     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: A then newline; a digit then a long gap closed by CR (space);
    // a token flushed by the end marker; extreme bytes as a foreign token;
    // a trailing gap flushed by the end marker (nothing).
    send_text(".-\n");
    send_text("-----     \r");
    send_text("....");
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(mtd_pkg::CH_TAB, 1'b0);
    send_text("- ");
    send_item(8'h00, 1'b1);
    wait_drained();

    // Random words; halfway the sender pauses until every result is back.
    while (sent < NUM_ITEMS) begin
      send_word();
      if (!paused && sent >= NUM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
